// File: design/igemm_pkg.sv
// ----------------------------------------------------------------------------
// igemm_pkg
// Shared types and constants of the int8 gemm core with dequant, bias and relu
// ----------------------------------------------------------------------------
package igemm_pkg;

  localparam int K_MAX   = 256;
  localparam int N_MAX   = 64;
  localparam int LANES   = 8;
  localparam int NGRP    = N_MAX / LANES;
  localparam int LANE_W  = $clog2(LANES);
  localparam int GRP_W   = $clog2(NGRP);
  localparam int ROW_W   = $clog2(K_MAX);
  localparam int COL_W   = $clog2(N_MAX);
  localparam int LEN_W   = 9;
  localparam int CNT_W   = 7;
  localparam int ACC_W   = 24;
  localparam int WADDR_W = ROW_W + GRP_W;

  localparam logic [31:0]      IN_SCALE_RST = 32'd16777216;
  localparam logic [LEN_W-1:0] LEN_RST      = 9'd256;
  localparam logic [CNT_W-1:0] CNT_RST      = 7'd64;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_COLUMN = 2'd1,
    OP_ACT    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_IN_SCALE  = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COL_COUNT = 2'd2,
    CFG_RELU      = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MAC_WB,
    ST_FIN_RD,
    ST_FIN_M1,
    ST_FIN_M2,
    ST_FIN_OUT
  } state_e;

  typedef struct packed {
    logic             load_wt;
    logic             load_col;
    logic             load_act;
    logic             mac_rd;
    logic [GRP_W-1:0] grp;
    logic [ROW_W-1:0] row;
    logic             fin;
    logic [COL_W-1:0] col;
    logic             fin_m1;
    logic             fin_m2;
    logic             fin_out;
    logic             clr_acc;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [GRP_W-1:0] last_grp;
    logic [COL_W-1:0] last_col;
    logic [LEN_W-1:0] len_m1;
  } status_t;

endpackage

// File: design/igemm_ram.sv
// ----------------------------------------------------------------------------
// igemm_ram
// Generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module igemm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/igemm_ctrl.sv
// ----------------------------------------------------------------------------
// igemm_ctrl
// Sequencer for loads, the mac sweep over column groups and the result pass
// ----------------------------------------------------------------------------
module igemm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         opcode_i,
  output logic               in_ready_o,
  input  igemm_pkg::status_t st_i,
  output igemm_pkg::cmd_t    cmd_o
);

  igemm_pkg::state_e                  state_q, state_d;
  logic [igemm_pkg::GRP_W-1:0]        grp_q, grp_d;
  logic [igemm_pkg::COL_W-1:0]        col_q, col_d;
  logic [igemm_pkg::LEN_W-1:0]        ictr_q, ictr_d;
  logic [igemm_pkg::LEN_W-1:0]        row;
  logic                               row_end;
  logic                               acc;
  igemm_pkg::op_e                     op;

  assign op      = igemm_pkg::op_e'(opcode_i);
  assign acc     = (state_q == igemm_pkg::ST_IDLE) && in_valid_i;
  assign row     = (ictr_q > st_i.len_m1) ? st_i.len_m1 : ictr_q;
  assign row_end = (row == st_i.len_m1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      igemm_pkg::ST_IDLE: begin
        if (acc && op == igemm_pkg::OP_ACT) state_d = igemm_pkg::ST_MAC;
      end
      igemm_pkg::ST_MAC: begin
        if (grp_q == st_i.last_grp) state_d = igemm_pkg::ST_MAC_WB;
      end
      igemm_pkg::ST_MAC_WB: begin
        state_d = row_end ? igemm_pkg::ST_FIN_RD : igemm_pkg::ST_IDLE;
      end
      igemm_pkg::ST_FIN_RD: state_d = igemm_pkg::ST_FIN_M1;
      igemm_pkg::ST_FIN_M1: state_d = igemm_pkg::ST_FIN_M2;
      igemm_pkg::ST_FIN_M2: state_d = igemm_pkg::ST_FIN_OUT;
      igemm_pkg::ST_FIN_OUT: begin
        if (st_i.out_free) begin
          state_d = (col_q == st_i.last_col) ? igemm_pkg::ST_IDLE : igemm_pkg::ST_FIN_RD;
        end
      end
      default: state_d = igemm_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    grp_d  = grp_q;
    col_d  = col_q;
    ictr_d = ictr_q;
    case (state_q)
      igemm_pkg::ST_IDLE: begin
        grp_d = '0;
        col_d = '0;
      end
      igemm_pkg::ST_MAC: grp_d = grp_q + 1'b1;
      igemm_pkg::ST_MAC_WB: begin
        if (!row_end) ictr_d = row + 1'b1;
      end
      igemm_pkg::ST_FIN_OUT: begin
        if (st_i.out_free) begin
          col_d = col_q + 1'b1;
          if (col_q == st_i.last_col) ictr_d = '0;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = (state_q == igemm_pkg::ST_IDLE);
    cmd_o.grp      = grp_q;
    cmd_o.row      = row[igemm_pkg::ROW_W-1:0];
    cmd_o.col      = col_q;
    cmd_o.load_wt  = acc && op == igemm_pkg::OP_WEIGHT;
    cmd_o.load_col = acc && op == igemm_pkg::OP_COLUMN;
    cmd_o.load_act = acc && op == igemm_pkg::OP_ACT;
    case (state_q)
      igemm_pkg::ST_MAC:    cmd_o.mac_rd = 1'b1;
      igemm_pkg::ST_FIN_RD: cmd_o.fin = 1'b1;
      igemm_pkg::ST_FIN_M1: begin
        cmd_o.fin    = 1'b1;
        cmd_o.fin_m1 = 1'b1;
      end
      igemm_pkg::ST_FIN_M2: begin
        cmd_o.fin    = 1'b1;
        cmd_o.fin_m2 = 1'b1;
      end
      igemm_pkg::ST_FIN_OUT: begin
        cmd_o.fin     = 1'b1;
        cmd_o.fin_out = st_i.out_free;
        cmd_o.clr_acc = st_i.out_free && (col_q == st_i.last_col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= igemm_pkg::ST_IDLE;
      grp_q   <= '0;
      col_q   <= '0;
      ictr_q  <= '0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      col_q   <= col_d;
      ictr_q  <= ictr_d;
    end
  end

`ifndef SYNTHESIS
  a_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == igemm_pkg::ST_MAC |-> grp_q <= st_i.last_grp)
    else $error("mac group beyond active columns");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> col_q <= st_i.last_col)
    else $error("result column beyond active columns");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_out |-> st_i.out_free)
    else $error("result loaded into a full output register");
  a_row_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_acc |=> ictr_q == '0)
    else $error("inner counter not cleared at row end");
`endif

endmodule

// File: design/igemm_dp.sv
// ----------------------------------------------------------------------------
// igemm_dp
// Config registers, weight and column stores, eight mac lanes, result pipeline
// ----------------------------------------------------------------------------
module igemm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic [7:0]                    inner_index_i,
  input  logic [5:0]                    column_index_i,
  input  logic signed [7:0]             weight_value_i,
  input  logic [31:0]                   column_scale_i,
  input  logic signed [31:0]            column_bias_i,
  input  logic signed [7:0]             activation_value_i,
  input  igemm_pkg::cmd_t               cmd_i,
  output igemm_pkg::status_t            st_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [5:0]                    out_column_o,
  output logic signed [31:0]            result_value_o,
  output logic                          last_of_row_o
);

  // configuration registers
  logic [31:0]                 in_scale_q;
  logic [igemm_pkg::LEN_W-1:0] len_q;
  logic [igemm_pkg::CNT_W-1:0] cnt_q;
  logic                        relu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_scale_q <= igemm_pkg::IN_SCALE_RST;
      len_q      <= igemm_pkg::LEN_RST;
      cnt_q      <= igemm_pkg::CNT_RST;
      relu_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (igemm_pkg::cfg_e'(cfg_addr_i))
        igemm_pkg::CFG_IN_SCALE:  in_scale_q <= cfg_wdata_i;
        igemm_pkg::CFG_INNER_LEN: len_q <= cfg_wdata_i[igemm_pkg::LEN_W-1:0];
        igemm_pkg::CFG_COL_COUNT: cnt_q <= cfg_wdata_i[igemm_pkg::CNT_W-1:0];
        igemm_pkg::CFG_RELU:      relu_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // effective length and column count
  logic [igemm_pkg::LEN_W-1:0] len_m1;
  logic [igemm_pkg::COL_W-1:0] last_col;

  always_comb begin
    if (len_q == '0) len_m1 = '0;
    else if (32'(len_q) > igemm_pkg::K_MAX) len_m1 = igemm_pkg::LEN_W'(igemm_pkg::K_MAX - 1);
    else len_m1 = len_q - 1'b1;
    if (cnt_q == '0) last_col = '0;
    else if (32'(cnt_q) > igemm_pkg::N_MAX) last_col = igemm_pkg::COL_W'(igemm_pkg::N_MAX - 1);
    else last_col = igemm_pkg::COL_W'(cnt_q - 1'b1);
  end

  // activation latch
  logic signed [7:0] act_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_act) act_q <= activation_value_i;
  end

  // lane stores and mac
  logic [igemm_pkg::GRP_W-1:0] acc_raddr;
  logic [igemm_pkg::GRP_W-1:0] wb_grp_q;
  logic                        wb_vld_q;
  logic [igemm_pkg::LANES-1:0] rvld_q, lane_act_q;
  logic [igemm_pkg::ACC_W-1:0] acc_rdata [igemm_pkg::LANES];
  logic [igemm_pkg::N_MAX-1:0] acc_vld_q;
  logic                        wt_ok;

  assign acc_raddr = cmd_i.fin ? cmd_i.col[igemm_pkg::COL_W-1:igemm_pkg::LANE_W] : cmd_i.grp;
  assign wt_ok     = 32'(inner_index_i) < igemm_pkg::K_MAX;

  for (genvar l = 0; l < igemm_pkg::LANES; l++) begin : g_lane
    logic [7:0]                  w_rdata;
    logic [igemm_pkg::ACC_W-1:0] sum;
    logic signed [15:0]          prod;

    igemm_ram #(.W(8), .D(igemm_pkg::K_MAX * igemm_pkg::NGRP)) u_wram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.load_wt && wt_ok &&
                column_index_i[igemm_pkg::LANE_W-1:0] == igemm_pkg::LANE_W'(l)),
      .waddr_i ({inner_index_i[igemm_pkg::ROW_W-1:0],
                 column_index_i[igemm_pkg::COL_W-1:igemm_pkg::LANE_W]}),
      .wdata_i (weight_value_i),
      .raddr_i ({cmd_i.row, cmd_i.grp}),
      .rdata_o (w_rdata)
    );

    assign prod = act_q * $signed(w_rdata);
    assign sum  = (rvld_q[l] ? acc_rdata[l] : '0) + igemm_pkg::ACC_W'(prod);

    igemm_ram #(.W(igemm_pkg::ACC_W), .D(igemm_pkg::NGRP)) u_aram (
      .clk_i   (clk_i),
      .we_i    (wb_vld_q && lane_act_q[l]),
      .waddr_i (wb_grp_q),
      .wdata_i (sum),
      .raddr_i (acc_raddr),
      .rdata_o (acc_rdata[l])
    );
  end

  // lane pipeline control captured at read issue
  always_ff @(posedge clk_i) begin
    wb_grp_q <= cmd_i.grp;
    for (int l = 0; l < igemm_pkg::LANES; l++) begin
      rvld_q[l]     <= acc_vld_q[{cmd_i.grp, igemm_pkg::LANE_W'(l)}];
      lane_act_q[l] <= ({cmd_i.grp, igemm_pkg::LANE_W'(l)} <= last_col);
    end
  end

  // writeback valid and accumulator valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q  <= 1'b0;
      acc_vld_q <= '0;
    end else begin
      wb_vld_q <= cmd_i.mac_rd;
      if (cmd_i.clr_acc) begin
        acc_vld_q <= '0;
      end else if (wb_vld_q) begin
        for (int l = 0; l < igemm_pkg::LANES; l++) begin
          if (lane_act_q[l]) acc_vld_q[{wb_grp_q, igemm_pkg::LANE_W'(l)}] <= 1'b1;
        end
      end
    end
  end

  // column scale and bias stores
  logic [31:0]                 scale_rdata, bias_rdata;
  logic [igemm_pkg::N_MAX-1:0] bias_vld_q;

  igemm_ram #(.W(32), .D(igemm_pkg::N_MAX)) u_sram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_col),
    .waddr_i (column_index_i),
    .wdata_i (column_scale_i),
    .raddr_i (cmd_i.col),
    .rdata_o (scale_rdata)
  );

  igemm_ram #(.W(32), .D(igemm_pkg::N_MAX)) u_bram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_col),
    .waddr_i (column_index_i),
    .wdata_i (column_bias_i),
    .raddr_i (cmd_i.col),
    .rdata_o (bias_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_vld_q <= '0;
    end else if (cmd_i.load_col) begin
      bias_vld_q[column_index_i] <= 1'b1;
    end
  end

  // result pipeline: input scale, column scale, bias, saturate, relu
  logic signed [igemm_pkg::ACC_W-1:0] acc_sel;
  logic signed [56:0]   p1;
  logic signed [31:0]   t1_q;
  logic signed [64:0]   p2;
  logic signed [56:0]   t2_q;
  logic signed [31:0]   bias_sel;
  logic signed [57:0]   vsum;
  logic signed [31:0]   vres;

  assign acc_sel  = acc_vld_q[cmd_i.col] ?
                    $signed(acc_rdata[cmd_i.col[igemm_pkg::LANE_W-1:0]]) : '0;
  assign p1       = acc_sel * $signed({1'b0, in_scale_q});
  assign p2       = t1_q * $signed({1'b0, scale_rdata});
  assign bias_sel = bias_vld_q[cmd_i.col] ? $signed(bias_rdata) : '0;
  assign vsum     = 58'(t2_q) + 58'(bias_sel);

  always_comb begin
    if (vsum > 58'sh7FFFFFFF) vres = 32'sh7FFFFFFF;
    else if (vsum < -58'sh80000000) vres = 32'sh80000000;
    else vres = vsum[31:0];
    if (relu_q && vres[31]) vres = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_m1) t1_q <= p1[55:24];
    if (cmd_i.fin_m2) t2_q <= p2[64:8];
  end

  // output register
  logic              out_vld_q;
  logic [5:0]        out_col_q;
  logic signed [31:0] out_res_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fin_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_out) begin
      out_col_q  <= cmd_i.col;
      out_res_q  <= vres;
      out_last_q <= (cmd_i.col == last_col);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_column_o   = out_col_q;
  assign result_value_o = out_res_q;
  assign last_of_row_o  = out_last_q;

  assign st_o.out_free = !out_vld_q || out_ready_i;
  assign st_o.last_grp = last_col[igemm_pkg::COL_W-1:igemm_pkg::LANE_W];
  assign st_o.last_col = last_col;
  assign st_o.len_m1   = len_m1;

endmodule

// File: design/int8_gemm_dequant_bias_relu_core.sv
// ----------------------------------------------------------------------------
// int8_gemm_dequant_bias_relu_core
// Int8 matrix-vector core with per-column dequant, bias and optional relu
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tuser = opcode; inner_index, column_index, weight, scale, bias, act
//  m_axis    | out       | out_column, result_value; tlast = last_of_row
//  cfg       | in        | write enable, register index, 32-bit data
//
//  loads (weight, column scale and bias) are taken in the idle state, which they do not leave
//  an activation runs eight mac lanes over the column groups, then writes back
//  a row end passes each column through read, two multiplier and output states
//  output stalls hold the result pass; input is not taken while busy
//  reset is asynchronous; accumulators and biases read zero via valid bits
// ----------------------------------------------------------------------------
module int8_gemm_dequant_bias_relu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  // inner_index, column_index, weight_value, column_scale, column_bias,
  // activation_value, zero pad
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_column, result_value, zero pad
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  igemm_pkg::cmd_t    cmd;
  igemm_pkg::status_t st;
  logic [5:0]         out_col;
  logic [31:0]        out_res;

  igemm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  igemm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .inner_index_i      (s_axis_tdata[7:0]),
    .column_index_i     (s_axis_tdata[13:8]),
    .weight_value_i     (s_axis_tdata[21:14]),
    .column_scale_i     (s_axis_tdata[53:22]),
    .column_bias_i      (s_axis_tdata[85:54]),
    .activation_value_i (s_axis_tdata[93:86]),
    .cmd_i              (cmd),
    .st_o               (st),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_column_o       (out_col),
    .result_value_o     (out_res),
    .last_of_row_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_res, out_col};

endmodule

// File: test/int8_gemm_dequant_bias_relu_core_tb.sv
// ----------------------------------------------------------------------------
// int8_gemm_dequant_bias_relu_core_tb
// Self-checking test of the int8 gemm core with dequant, bias and relu: rows of
// activations run against loaded weights and column parameters under several
// register settings, and every result is compared with a local prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module int8_gemm_dequant_bias_relu_core_tb;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  inner_index;
    logic [5:0]  column_index;
    logic [7:0]  weight_value;
    logic [31:0] column_scale;
    logic [31:0] column_bias;
    logic [7:0]  activation_value;
  } item_t;

  typedef struct packed {
    logic [5:0]  column;
    logic [31:0] value;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // local copy of the block state
  logic [7:0]        wt_mem [igemm_pkg::K_MAX][igemm_pkg::N_MAX];
  logic [31:0]       scale_mem [igemm_pkg::N_MAX];
  logic [31:0]       bias_mem [igemm_pkg::N_MAX];
  logic signed [23:0] acc_mem [igemm_pkg::N_MAX];
  int                row_pos;
  logic [31:0]       in_scale_q;
  logic [8:0]        len_q;
  logic [6:0]        cnt_q;
  logic              relu_q;

  result_t expected_q [$];
  int      fail_cnt = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  bit      sat_seen = 0;
  bit      rx_steady = 0;

  int8_gemm_dequant_bias_relu_core u_top (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int eff_len();
    if (len_q == 0) return 1;
    if (len_q > igemm_pkg::K_MAX) return igemm_pkg::K_MAX;
    return len_q;
  endfunction

  function automatic int eff_cnt();
    if (cnt_q == 0) return 1;
    if (cnt_q > igemm_pkg::N_MAX) return igemm_pkg::N_MAX;
    return cnt_q;
  endfunction

  // dequant, bias, saturate, relu
  function automatic logic [31:0] dequant(logic signed [23:0] acc, logic [31:0] cs,
                                          logic [31:0] bias);
    logic signed [63:0] t1, t2;
    logic signed [127:0] p;
    logic signed [63:0] v;
    p  = 128'(signed'(acc)) * $signed({96'd0, in_scale_q});
    t1 = 64'(p >>> 24);
    p  = 128'(t1) * $signed({96'd0, cs});
    t2 = 64'(p >>> 8);
    v  = t2 + 64'(signed'(bias));
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat_seen = 1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat_seen = 1;
    end
    if (relu_q && v < 0) v = 0;
    return v[31:0];
  endfunction

  // update predicted state for one accepted item
  function automatic void predict_item(item_t it);
    int len, cnt;
    logic signed [23:0] prod;
    result_t r;
    case (igemm_pkg::op_e'(it.opcode))
      igemm_pkg::OP_WEIGHT: wt_mem[it.inner_index][it.column_index] = it.weight_value;
      igemm_pkg::OP_COLUMN: begin
        scale_mem[it.column_index] = it.column_scale;
        bias_mem[it.column_index] = it.column_bias;
      end
      igemm_pkg::OP_ACT: begin
        len = eff_len();
        cnt = eff_cnt();
        if (row_pos >= len) row_pos = len - 1;
        for (int c = 0; c < cnt; c++) begin
          prod = 24'(signed'(it.activation_value) * signed'(wt_mem[row_pos][c]));
          acc_mem[c] = acc_mem[c] + prod;
        end
        if (row_pos + 1 >= len) begin
          for (int c = 0; c < cnt; c++) begin
            r.column = c[5:0];
            r.value = dequant(acc_mem[c], scale_mem[c], bias_mem[c]);
            r.last = (c + 1 == cnt);
            expected_q.push_back(r);
          end
          foreach (acc_mem[c]) acc_mem[c] = '0;
          row_pos = 0;
        end else begin
          row_pos++;
        end
      end
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high after acceptance until the next gap or idle step
  task automatic send_item(item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.opcode;
    s_axis_tdata <= {2'd0, it.activation_value, it.column_bias, it.column_scale,
                     it.weight_value, it.column_index, it.inner_index};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(it);
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0 && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    // row end pipeline latency margin
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(igemm_pkg::cfg_e idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      igemm_pkg::CFG_IN_SCALE:  in_scale_q = val;
      igemm_pkg::CFG_INNER_LEN: len_q = val[8:0];
      igemm_pkg::CFG_COL_COUNT: cnt_q = val[6:0];
      igemm_pkg::CFG_RELU:      relu_q = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic item_t rand_item(igemm_pkg::op_e op);
    item_t it;
    it.opcode = op;
    it.inner_index = 8'($urandom);
    it.column_index = 6'($urandom);
    it.weight_value = 8'($urandom);
    it.column_scale = $urandom;
    it.column_bias = $urandom;
    it.activation_value = 8'($urandom);
    return it;
  endfunction

  // fill weights for the used rows and columns, and column parameters
  task automatic load_matrix(int rows, int cols, bit wide_scale);
    item_t it;
    for (int c = 0; c < cols; c++) begin
      it = rand_item(igemm_pkg::OP_COLUMN);
      it.column_index = 6'(c);
      if (!wide_scale) it.column_scale = $urandom_range(0, 32'h0400_0000);
      send_item(it);
    end
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) begin
        it = rand_item(igemm_pkg::OP_WEIGHT);
        it.inner_index = 8'(r);
        it.column_index = 6'(c);
        send_item(it);
      end
  endtask

  task automatic run_rows(int n);
    for (int i = 0; i < n; i++) send_item(rand_item(igemm_pkg::OP_ACT));
  endtask

  // extremes of weights and activations, bias and relu
  task automatic test_directed();
    item_t it;
    write_reg(igemm_pkg::CFG_INNER_LEN, 2);
    write_reg(igemm_pkg::CFG_COL_COUNT, 2);
    write_reg(igemm_pkg::CFG_RELU, 0);
    write_reg(igemm_pkg::CFG_IN_SCALE, 32'h0100_0000);
    it = rand_item(igemm_pkg::OP_COLUMN);
    it.column_index = 6'd0; it.column_scale = 32'hFFFF_FFFF; it.column_bias = 32'h7FFF_FFFF;
    send_item(it);
    it.column_index = 6'd1; it.column_scale = 32'h0100_0000; it.column_bias = 32'h8000_0000;
    send_item(it);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) begin
        it = rand_item(igemm_pkg::OP_WEIGHT);
        it.inner_index = 8'(r); it.column_index = 6'(c);
        it.weight_value = (c == 0) ? 8'h80 : 8'h7F;
        send_item(it);
      end
    it = rand_item(igemm_pkg::OP_ACT);
    it.activation_value = 8'h80; send_item(it);
    it.activation_value = 8'h7F; send_item(it);
    it.activation_value = 8'h80; send_item(it);
    it.activation_value = 8'h80; send_item(it);
    // unknown opcode is ignored
    send_item(rand_item(igemm_pkg::OP_NONE));
    drain();
    write_reg(igemm_pkg::CFG_RELU, 1);
    run_rows(4);
    drain();
  endtask

  // single element rows and one column, zero register values acting as one
  task automatic test_min_sizes();
    write_reg(igemm_pkg::CFG_INNER_LEN, 0);
    write_reg(igemm_pkg::CFG_COL_COUNT, 0);
    write_reg(igemm_pkg::CFG_IN_SCALE, 32'h0000_0000);
    load_matrix(1, 1, 1'b1);
    run_rows(3);
    drain();
    write_reg(igemm_pkg::CFG_IN_SCALE, 32'hFFFF_FFFF);
    write_reg(igemm_pkg::CFG_INNER_LEN, 1);
    write_reg(igemm_pkg::CFG_COL_COUNT, 1);
    run_rows(3);
    drain();
  endtask

  // full width rows, column count above the limit
  task automatic test_max_sizes();
    write_reg(igemm_pkg::CFG_IN_SCALE, 32'h0100_0000);
    write_reg(igemm_pkg::CFG_COL_COUNT, 32'h7F);
    write_reg(igemm_pkg::CFG_INNER_LEN, 1);
    write_reg(igemm_pkg::CFG_RELU, 0);
    load_matrix(1, 64, 1'b0);
    run_rows(3);
    drain();
  endtask

  // length above the limit holds the row open, then a mid-row shortening
  task automatic test_long_and_shorten();
    item_t it;
    write_reg(igemm_pkg::CFG_COL_COUNT, 1);
    write_reg(igemm_pkg::CFG_INNER_LEN, 32'h1FF);
    for (int r = 0; r < 40; r++) begin
      it = rand_item(igemm_pkg::OP_WEIGHT);
      it.inner_index = 8'(r); it.column_index = 6'd0; it.weight_value = 8'h80;
      send_item(it);
    end
    it = rand_item(igemm_pkg::OP_ACT);
    for (int i = 0; i < 40; i++) begin
      it.activation_value = 8'h80;
      send_item(it);
    end
    drain();
    write_reg(igemm_pkg::CFG_INNER_LEN, 20);
    run_rows(1);
    drain();
  endtask

  // random traffic: configs, loads, ignored ops and rows
  task automatic test_random(int phases);
    int len, cnt, p, n;
    item_t it;
    for (int ph = 0; ph < phases; ph++) begin
      len = $urandom_range(1, 4);
      cnt = $urandom_range(1, 10);
      write_reg(igemm_pkg::CFG_INNER_LEN, len);
      write_reg(igemm_pkg::CFG_COL_COUNT, cnt);
      write_reg(igemm_pkg::CFG_RELU, $urandom_range(0, 1));
      write_reg(igemm_pkg::CFG_IN_SCALE,
                (ph == phases - 1) ? $urandom : $urandom_range(0, 32'h0400_0000));
      load_matrix(len, cnt, ph == phases - 1);
      n = 0;
      while (n < 20) begin
        p = $urandom_range(0, 19);
        if (p < 2) begin
          it = rand_item(igemm_pkg::OP_WEIGHT);
          it.inner_index = 8'($urandom_range(0, len - 1));
          it.column_index = 6'($urandom_range(0, cnt - 1));
        end else if (p < 3) begin
          it = rand_item(igemm_pkg::OP_COLUMN);
          it.column_index = 6'($urandom_range(0, cnt - 1));
        end else if (p < 4) begin
          it = rand_item(igemm_pkg::OP_NONE);
        end else begin
          it = rand_item(igemm_pkg::OP_ACT);
          n++;
        end
        send_item(it);
      end
      drain();
    end
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    if (rx_steady) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 8) m_axis_tready <= 1'b0;
    else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 99) < 30);
    else m_axis_tready <= 1'b1;
  end

  // result check
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.column = m_axis_tdata[5:0];
      got.value = m_axis_tdata[37:6];
      got.last = m_axis_tlast;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction col=%0d val=%h", got.column, got.value);
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.column !== exp_r.column) begin
          $error("out_column exp %0d got %0d", exp_r.column, got.column);
          fail_cnt++;
        end
        if (got.value !== exp_r.value) begin
          $error("result_value exp %h got %h", exp_r.value, got.value);
          fail_cnt++;
        end
        if (got.last !== exp_r.last) begin
          $error("last_of_row exp %0b got %0b", exp_r.last, got.last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    foreach (acc_mem[c]) begin
      acc_mem[c] = '0;
      bias_mem[c] = '0;
      scale_mem[c] = '0;
    end
    row_pos = 0;
    in_scale_q = igemm_pkg::IN_SCALE_RST;
    len_q = igemm_pkg::LEN_RST;
    cnt_q = igemm_pkg::CNT_RST;
    relu_q = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_min_sizes();
    test_max_sizes();
    test_long_and_shorten();
    rx_steady = 1;
    test_random(3);
    rx_steady = 0;
    test_random(3);
    drain();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fail_cnt++;
    end
    $display("sent %0d items, checked %0d results, saturation hit: %0b",
             items_sent, results_seen, sat_seen);
    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
